// ----- rtl/ps2mh_pkg.sv -----
// Shared types and constants for the PS/2 mouse host link.
package ps2mh_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SEND = 2'd1;
   localparam logic [1:0] OP_RECV = 2'd2;

   // The acknowledge byte sent by the mouse is never stored in a packet.
   localparam logic [7:0] ACK_BYTE = 8'hFA;

   // Reset value of the clock inhibit length, in ticks.
   localparam logic [15:0] INHIBIT_RESET = 16'd205;

   // Bit slots of one host-to-device frame after the start bit.
   localparam logic [3:0] LAST_DATA_SLOT = 4'd7;
   localparam logic [3:0] PARITY_SLOT    = 4'd8;
   localparam logic [3:0] STOP_SLOT      = 4'd9;

   // Transmit sequencer states.
   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_INHIBIT   = 5'b00010,
      PH_START     = 5'b00100,
      PH_WAIT_LOW  = 5'b01000,
      PH_WAIT_HIGH = 5'b10000
   } phase_type;

endpackage

// ----- rtl/ps2_mouse_host_link_core.sv -----
// PS/2 mouse host link: command transmit sequencer and packet assembler.
//
//   channel   direction  ports                               handshake
//   req_      in         operation, cmd_byte, clk_level,     valid / ready
//                        rx_byte
//   rsp_      out        data_low, clk_low, busy_res,        valid / ready
//                        done_res, packet_ready, pkt_byte0..2
//   csr_      in         wdata (inhibit length)              write enable
//
// Each request is handled in the cycle it is accepted and its response appears
// in the output register on the next cycle, so one request per cycle is taken while not stalled.
// The output register parts the two sides: a request is accepted whenever the
// response register is empty or is being emptied in the same cycle.
// A response stalled by rsp_ready low holds its payload and blocks new requests.
// Synchronous reset returns the sequencer to idle with no response pending.
module ps2_mouse_host_link_core #(
   parameter int PACKET_BYTES = 3
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_cmd_byte,
   input  logic        req_clk_level,
   input  logic [7:0]  req_rx_byte,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_data_low,
   output logic        rsp_clk_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_packet_ready,
   output logic [7:0]  rsp_pkt_byte0,
   output logic [7:0]  rsp_pkt_byte1,
   output logic [7:0]  rsp_pkt_byte2,
   // Configuration port
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import ps2mh_pkg::*;

   localparam int IdxWidth = $clog2(PACKET_BYTES);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(PACKET_BYTES - 1);

   // Sequencer and packet state.
   phase_type           phase_ff, phase_in;
   logic [15:0]         hold_count_ff, hold_count_in;
   logic [3:0]          bit_slot_ff, bit_slot_in;
   logic [7:0]          tx_shift_ff, tx_shift_in;
   logic                tx_parity_ff, tx_parity_in;
   logic [IdxWidth-1:0] pkt_index_ff, pkt_index_in;
   logic                ready_flag_ff, ready_flag_in;
   logic                data_drive_ff, data_drive_in;
   logic [15:0]         inhibit_ticks_ff;
   logic [7:0]          pkt_store_ff [PACKET_BYTES];

   // Store write request for the current item.
   logic                store_we;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                done_in;
   logic                rsp_data_low_ff, rsp_clk_low_ff, rsp_busy_ff, rsp_done_ff;
   logic                rsp_ready_flag_ff;
   logic [7:0]          rsp_byte0_ff, rsp_byte1_ff, rsp_byte2_ff;
   logic [7:0]          byte0_in, byte1_in, byte2_in;

   logic                accept;

   // Level the host drives for a frame slot: 1 pulls the data line low.
   function automatic logic slot_drive(input logic [3:0] slot, input logic [7:0] shift,
                                       input logic parity);
      logic drive;
      drive = 1'b0;
      if (slot <= LAST_DATA_SLOT) begin
         drive = ~shift[slot[2:0]];
      end else if (slot == PARITY_SLOT) begin
         drive = ~parity;
      end
      return drive;
   endfunction

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // Next state for the accepted request.
   always_comb begin
      phase_in      = phase_ff;
      hold_count_in = hold_count_ff;
      bit_slot_in   = bit_slot_ff;
      tx_shift_in   = tx_shift_ff;
      tx_parity_in  = tx_parity_ff;
      pkt_index_in  = pkt_index_ff;
      ready_flag_in = ready_flag_ff;
      data_drive_in = data_drive_ff;
      store_we      = 1'b0;
      done_in       = 1'b0;
      if (accept) begin
         if (phase_ff == PH_IDLE) begin
            unique case (req_operation)
               OP_SEND: begin
                  tx_shift_in   = req_cmd_byte;
                  tx_parity_in  = ~^req_cmd_byte;
                  hold_count_in = inhibit_ticks_ff;
                  bit_slot_in   = '0;
                  data_drive_in = 1'b0;
                  phase_in      = PH_INHIBIT;
               end
               OP_RECV: begin
                  if (!ready_flag_ff && req_rx_byte != ACK_BYTE) begin
                     store_we = 1'b1;
                     if (pkt_index_ff == LastIdx) begin
                        pkt_index_in  = '0;
                        ready_flag_in = 1'b1;
                     end else begin
                        pkt_index_in = pkt_index_ff + 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end else if (req_operation == OP_TICK) begin
            unique case (phase_ff)
               PH_INHIBIT: begin
                  if (hold_count_ff > 16'd1) begin
                     hold_count_in = hold_count_ff - 16'd1;
                  end else begin
                     hold_count_in = '0;
                     data_drive_in = 1'b1;
                     phase_in      = PH_START;
                  end
               end
               PH_START: begin
                  if (req_clk_level) begin
                     bit_slot_in = '0;
                     phase_in    = PH_WAIT_LOW;
                  end
               end
               PH_WAIT_LOW: begin
                  if (!req_clk_level) begin
                     data_drive_in = slot_drive(bit_slot_ff, tx_shift_ff, tx_parity_ff);
                     phase_in      = PH_WAIT_HIGH;
                  end
               end
               PH_WAIT_HIGH: begin
                  if (req_clk_level) begin
                     if (bit_slot_ff >= STOP_SLOT) begin
                        data_drive_in = 1'b0;
                        bit_slot_in   = '0;
                        pkt_index_in  = '0;
                        ready_flag_in = 1'b0;
                        phase_in      = PH_IDLE;
                        done_in       = 1'b1;
                     end else begin
                        bit_slot_in = bit_slot_ff + 4'd1;
                        phase_in    = PH_WAIT_LOW;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Packet bytes as seen after this item; the byte being written is forwarded; all read zero while no packet is ready.
   always_comb begin
      byte0_in = pkt_store_ff[0];
      byte1_in = pkt_store_ff[1];
      byte2_in = pkt_store_ff[2];
      if (store_we) begin
         case (pkt_index_ff)
            IdxWidth'(0): byte0_in = req_rx_byte;
            IdxWidth'(1): byte1_in = req_rx_byte;
            IdxWidth'(2): byte2_in = req_rx_byte;
            default: begin
            end
         endcase
      end
      if (!ready_flag_in) begin
         byte0_in = '0;
         byte1_in = '0;
         byte2_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         hold_count_ff    <= '0;
         bit_slot_ff      <= '0;
         tx_shift_ff      <= '0;
         tx_parity_ff     <= 1'b1;
         pkt_index_ff     <= '0;
         ready_flag_ff    <= 1'b0;
         data_drive_ff    <= 1'b0;
         inhibit_ticks_ff <= INHIBIT_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hold_count_ff <= hold_count_in;
         bit_slot_ff   <= bit_slot_in;
         tx_shift_ff   <= tx_shift_in;
         tx_parity_ff  <= tx_parity_in;
         pkt_index_ff  <= pkt_index_in;
         ready_flag_ff <= ready_flag_in;
         data_drive_ff <= data_drive_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            inhibit_ticks_ff <= csr_wdata;
         end
      end
   end

   // Packet store, written one byte per received request in idle, unless it is an acknowledge or a packet is held.
   always_ff @(posedge clock) begin
      if (store_we) begin
         pkt_store_ff[pkt_index_ff] <= req_rx_byte;
      end
   end

   // Response payload, loaded with the state left by the accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_low_ff   <= data_drive_in;
         rsp_clk_low_ff    <= (phase_in == PH_INHIBIT);
         rsp_busy_ff       <= (phase_in != PH_IDLE);
         rsp_done_ff       <= done_in;
         rsp_ready_flag_ff <= ready_flag_in;
         rsp_byte0_ff      <= byte0_in;
         rsp_byte1_ff      <= byte1_in;
         rsp_byte2_ff      <= byte2_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_low     = rsp_data_low_ff;
   assign rsp_clk_low      = rsp_clk_low_ff;
   assign rsp_busy_res     = rsp_busy_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_packet_ready = rsp_ready_flag_ff;
   assign rsp_pkt_byte0    = rsp_byte0_ff;
   assign rsp_pkt_byte1    = rsp_byte1_ff;
   assign rsp_pkt_byte2    = rsp_byte2_ff;

endmodule

// ----- rtl/ps2mh_checker.sv -----
// Port-level checks for the PS/2 mouse host link, bound to the link core.
module ps2mh_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_data_low,
   input logic       rsp_clk_low,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic       rsp_packet_ready,
   input logic [7:0] rsp_pkt_byte0,
   input logic [7:0] rsp_pkt_byte1,
   input logic [7:0] rsp_pkt_byte2
);

   // No response is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The clock is only inhibited during a transmission, with data released.
   a_inhibit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clk_low) |-> (rsp_busy_res && !rsp_data_low))
      else $error("clock inhibit outside transmission or with data driven");

   // Finishing a command leaves the link idle with the packet cleared.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (!rsp_busy_res && !rsp_packet_ready && !rsp_data_low))
      else $error("done with link still busy or packet held");

   // Packet bytes read as zero while no packet is held.
   a_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_packet_ready) |->
         (rsp_pkt_byte0 == 8'd0 && rsp_pkt_byte1 == 8'd0 && rsp_pkt_byte2 == 8'd0))
      else $error("packet bytes shown without a packet");

   // A stalled response stays valid and keeps its data-low, done and first packet byte.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_data_low) && $stable(rsp_done_res)
          && $stable(rsp_pkt_byte0)))
      else $error("stalled response changed");

endmodule

bind ps2_mouse_host_link_core ps2mh_checker u_ps2mh_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_data_low     (rsp_data_low),
   .rsp_clk_low      (rsp_clk_low),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_done_res     (rsp_done_res),
   .rsp_packet_ready (rsp_packet_ready),
   .rsp_pkt_byte0    (rsp_pkt_byte0),
   .rsp_pkt_byte1    (rsp_pkt_byte1),
   .rsp_pkt_byte2    (rsp_pkt_byte2)
);
